// ===== design/qrm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qrm_pkg
// Shared constants and types for the quaternion to rotation matrix pipeline.
// ----------------------------------------------------------------------------
package qrm_pkg;

    localparam int FRAC_BITS_DEF = 14;

    localparam int IN_W   = 16;           // quaternion component width
    localparam int OUT_W  = 16;           // matrix entry width
    localparam int PROD_W = 2 * IN_W;     // one component product
    localparam int NUM_W  = PROD_W + 3;   // entry numerator, signed
    localparam int DEN_W  = PROD_W + 1;   // sum of four squares, unsigned
    localparam int REM_W  = DEN_W + 1;    // divider partial remainder
    localparam int N_PROD = 10;
    localparam int N_ENT  = 9;

    // product slots
    localparam int P_WW = 0;
    localparam int P_XX = 1;
    localparam int P_YY = 2;
    localparam int P_ZZ = 3;
    localparam int P_WX = 4;
    localparam int P_WY = 5;
    localparam int P_WZ = 6;
    localparam int P_XY = 7;
    localparam int P_XZ = 8;
    localparam int P_YZ = 9;

    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [NUM_W-1:0]  t_num;
    typedef logic        [DEN_W-1:0]  t_den;
    typedef logic        [REM_W-1:0]  t_rem;
    typedef logic        [OUT_W-1:0]  t_entry;

endpackage : qrm_pkg
`default_nettype wire

// ===== design/quaternion_to_rotation_matrix.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix
// Pipelined conversion of a Q1.14 quaternion to a normalized 3x3 rotation
// matrix, rounded half away from zero and saturated to +/-1.0.
// ----------------------------------------------------------------------------
// A request is taken on every clock edge with start high; busy is always low,
// so one quaternion per cycle is accepted. Each result appears on the o_m*
// ports for one cycle with o_valid high, after the product, numerator and
// norm, divider setup, quotient-bit and output registers. The restoring
// divider resolves one quotient bit per pipeline stage for all nine
// entries in parallel. The receiver cannot stall the pipeline, and none is
// needed. A zero quaternion gives o_zero_error high and all entries zero.
module quaternion_to_rotation_matrix
    import qrm_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     start,
    output logic                    busy,
    input  wire  signed [IN_W-1:0]  i_quat_w,
    input  wire  signed [IN_W-1:0]  i_quat_x,
    input  wire  signed [IN_W-1:0]  i_quat_y,
    input  wire  signed [IN_W-1:0]  i_quat_z,
    output logic                    o_valid,
    output logic signed [OUT_W-1:0] o_m00,
    output logic signed [OUT_W-1:0] o_m01,
    output logic signed [OUT_W-1:0] o_m02,
    output logic signed [OUT_W-1:0] o_m10,
    output logic signed [OUT_W-1:0] o_m11,
    output logic signed [OUT_W-1:0] o_m12,
    output logic signed [OUT_W-1:0] o_m20,
    output logic signed [OUT_W-1:0] o_m21,
    output logic signed [OUT_W-1:0] o_m22,
    output logic                    o_zero_error
);

    localparam int QW    = FRAC_BITS + 1;              // quotient bits, 2x scale
    localparam int EXT_W = (QW > OUT_W) ? QW : OUT_W;

    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // stage p: ten products
    // ------------------------------------------------------------------
    logic  r_p_vld;
    t_prod r_p_prod [N_PROD];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else begin
            r_p_vld <= start & ~busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_prod[P_WW] <= i_quat_w * i_quat_w;
        r_p_prod[P_XX] <= i_quat_x * i_quat_x;
        r_p_prod[P_YY] <= i_quat_y * i_quat_y;
        r_p_prod[P_ZZ] <= i_quat_z * i_quat_z;
        r_p_prod[P_WX] <= i_quat_w * i_quat_x;
        r_p_prod[P_WY] <= i_quat_w * i_quat_y;
        r_p_prod[P_WZ] <= i_quat_w * i_quat_z;
        r_p_prod[P_XY] <= i_quat_x * i_quat_y;
        r_p_prod[P_XZ] <= i_quat_x * i_quat_z;
        r_p_prod[P_YZ] <= i_quat_y * i_quat_z;
    end

    // ------------------------------------------------------------------
    // stage s: numerators and norm
    // ------------------------------------------------------------------
    logic r_s_vld;
    t_num r_s_num [N_ENT];
    t_den r_s_den;
    t_num n_s_num [N_ENT];
    t_num n_s_sum;

    always_comb begin
        t_num ww, xx, yy, zz, wx, wy, wz, xy, xz, yz;
        ww = NUM_W'(r_p_prod[P_WW]);
        xx = NUM_W'(r_p_prod[P_XX]);
        yy = NUM_W'(r_p_prod[P_YY]);
        zz = NUM_W'(r_p_prod[P_ZZ]);
        wx = NUM_W'(r_p_prod[P_WX]);
        wy = NUM_W'(r_p_prod[P_WY]);
        wz = NUM_W'(r_p_prod[P_WZ]);
        xy = NUM_W'(r_p_prod[P_XY]);
        xz = NUM_W'(r_p_prod[P_XZ]);
        yz = NUM_W'(r_p_prod[P_YZ]);
        n_s_num[0] = ww + xx - yy - zz;
        n_s_num[1] = (wz + xy) <<< 1;
        n_s_num[2] = (xz - wy) <<< 1;
        n_s_num[3] = (xy - wz) <<< 1;
        n_s_num[4] = ww - xx + yy - zz;
        n_s_num[5] = (wx + yz) <<< 1;
        n_s_num[6] = (wy + xz) <<< 1;
        n_s_num[7] = (yz - wx) <<< 1;
        n_s_num[8] = ww - xx - yy + zz;
        n_s_sum    = ww + xx + yy + zz;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_vld <= 1'b0;
        end else begin
            r_s_vld <= r_p_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s_num <= n_s_num;
        r_s_den <= n_s_sum[DEN_W-1:0];
    end

    // ------------------------------------------------------------------
    // divider: slot 0 holds sign/magnitude setup, slots 1..QW one
    // quotient bit each
    // ------------------------------------------------------------------
    logic          r_d_vld [QW+1];
    logic          r_d_err [QW+1];
    t_den          r_d_den [QW+1];
    logic          r_d_neg [QW+1][N_ENT];
    logic          r_d_sat [QW+1][N_ENT];
    t_rem          r_d_rem [QW+1][N_ENT];
    logic [QW-1:0] r_d_quo [QW+1][N_ENT];

    logic n_m_neg [N_ENT];
    logic n_m_sat [N_ENT];
    t_rem n_m_rem [N_ENT];

    always_comb begin
        t_num mag;
        for (int i = 0; i < N_ENT; i++) begin
            n_m_neg[i] = r_s_num[i][NUM_W-1];
            mag        = n_m_neg[i] ? -r_s_num[i] : r_s_num[i];
            // |num| >= norm rounds to full scale
            n_m_sat[i] = (mag >= NUM_W'(r_s_den));
            n_m_rem[i] = n_m_sat[i] ? '0 : mag[REM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld[0] <= 1'b0;
        end else begin
            r_d_vld[0] <= r_s_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d_err[0] <= (r_s_den == '0);
        r_d_den[0] <= r_s_den;
        for (int i = 0; i < N_ENT; i++) begin
            r_d_neg[0][i] <= n_m_neg[i];
            r_d_sat[0][i] <= n_m_sat[i];
            r_d_rem[0][i] <= n_m_rem[i];
            r_d_quo[0][i] <= '0;
        end
    end

    for (genvar k = 1; k <= QW; k++) begin : g_div
        t_rem          n_rem [N_ENT];
        logic [QW-1:0] n_quo [N_ENT];

        always_comb begin
            t_rem shifted;
            logic ge;
            for (int i = 0; i < N_ENT; i++) begin
                shifted  = {r_d_rem[k-1][i][REM_W-2:0], 1'b0};
                ge       = (shifted >= REM_W'(r_d_den[k-1]));
                n_rem[i] = ge ? shifted - REM_W'(r_d_den[k-1]) : shifted;
                n_quo[i] = {r_d_quo[k-1][i][QW-2:0], ge};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_d_vld[k] <= 1'b0;
            end else begin
                r_d_vld[k] <= r_d_vld[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            r_d_err[k] <= r_d_err[k-1];
            r_d_den[k] <= r_d_den[k-1];
            for (int i = 0; i < N_ENT; i++) begin
                r_d_neg[k][i] <= r_d_neg[k-1][i];
                r_d_sat[k][i] <= r_d_sat[k-1][i];
                r_d_rem[k][i] <= n_rem[i];
                r_d_quo[k][i] <= n_quo[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // output: round the doubled quotient, apply sign, force zero on error
    // ------------------------------------------------------------------
    logic   r_out_vld;
    logic   r_out_err;
    t_entry r_out_m [N_ENT];
    t_entry n_out_m [N_ENT];

    always_comb begin
        logic [QW:0]      qsum;
        logic [QW-1:0]    q;
        logic [EXT_W-1:0] ext;
        logic [EXT_W-1:0] val;
        for (int i = 0; i < N_ENT; i++) begin
            qsum = {1'b0, r_d_quo[QW][i]} + (QW+1)'(1);
            q    = r_d_sat[QW][i] ? (QW'(1) << FRAC_BITS) : qsum[QW:1];
            ext  = EXT_W'(q);
            val  = r_d_neg[QW][i] ? -ext : ext;
            n_out_m[i] = r_d_err[QW] ? '0 : val[OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_d_vld[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_err <= r_d_err[QW];
        r_out_m   <= n_out_m;
    end

    assign o_valid      = r_out_vld;
    assign o_zero_error = r_out_err;
    assign o_m00        = r_out_m[0];
    assign o_m01        = r_out_m[1];
    assign o_m02        = r_out_m[2];
    assign o_m10        = r_out_m[3];
    assign o_m11        = r_out_m[4];
    assign o_m12        = r_out_m[5];
    assign o_m20        = r_out_m[6];
    assign o_m21        = r_out_m[7];
    assign o_m22        = r_out_m[8];

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_err_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_zero_error |->
            o_m00 == '0 && o_m01 == '0 && o_m02 == '0 &&
            o_m10 == '0 && o_m11 == '0 && o_m12 == '0 &&
            o_m20 == '0 && o_m21 == '0 && o_m22 == '0)
        else $error("zero quaternion gave nonzero entries");

    a_rem_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_d_vld[QW] && !r_d_err[QW] |->
            r_d_rem[QW][0] < REM_W'(r_d_den[QW]) &&
            r_d_rem[QW][4] < REM_W'(r_d_den[QW]) &&
            r_d_rem[QW][8] < REM_W'(r_d_den[QW]))
        else $error("divider remainder not below norm");

    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_p_vld, QW + 3))
        else $error("result strobe without matching request");

    a_no_spurious_err : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_d_vld[0] |-> r_d_err[0] == (r_d_den[0] == '0))
        else $error("error flag does not match norm");

endmodule : quaternion_to_rotation_matrix
`default_nettype wire
